FILE: rtl/qrpm_pkg.sv
package qrpm_pkg;

  // Fixed-point layout
  localparam int PULSE_PERIOD   = 2100;
  localparam int SUM_W          = 32;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int RATE_FRAC_BITS = 4;
  localparam int TERM_SHIFT     = RATE_FRAC_BITS + GAIN_FRAC_BITS;

  localparam int NUM_AXES = 3;
  localparam int AXIS_PITCH = 0;
  localparam int AXIS_ROLL  = 1;
  localparam int AXIS_YAW   = 2;

  localparam int RATE_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = RATE_W + 1;
  localparam int DERR_W  = ERR_W + 1;
  localparam int PP_W    = GAIN_W + ERR_W;
  localparam int PI_W    = GAIN_W + SUM_W;
  localparam int PD_W    = GAIN_W + DERR_W;
  localparam int ACC_W   = PI_W + 2;
  localparam int TERM_W  = ACC_W - TERM_SHIFT;
  localparam int THR_W   = 13;
  localparam int MIX_W   = TERM_W + 2;
  localparam int PULSE_W = 12;

  localparam int GAINS_W = 3 * GAIN_W;

  // Register map, index is paddr[5:3]
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_GAINS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROLL_GAINS  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_YAW_GAINS   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MOTOR_MIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MOTOR_MAX   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TEST_SEL    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TEST_PULSE  = 3'd6;

  localparam logic [PULSE_W-1:0] MOTOR_MIN_RST = 12'd1000;
  localparam logic [PULSE_W-1:0] MOTOR_MAX_RST = 12'd2000;

  // Test motor select codes
  localparam logic [2:0] TSEL_NONE  = 3'd0;
  localparam logic [2:0] TSEL_ONE   = 3'd1;
  localparam logic [2:0] TSEL_TWO   = 3'd2;
  localparam logic [2:0] TSEL_THREE = 3'd3;
  localparam logic [2:0] TSEL_FOUR  = 3'd4;

  typedef struct packed {
    logic signed [12:0] throttle;
    logic signed [15:0] target_pitch;
    logic signed [15:0] target_roll;
    logic signed [15:0] target_yaw;
    logic signed [15:0] rate_pitch;
    logic signed [15:0] rate_roll;
    logic signed [15:0] rate_yaw;
  } sample_t;

  typedef struct packed {
    logic [11:0] compare_one;
    logic [11:0] compare_two;
    logic [11:0] compare_three;
    logic [11:0] compare_four;
  } motor_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][GAINS_W-1:0] gains;
    logic [PULSE_W-1:0]               motor_min;
    logic [PULSE_W-1:0]               motor_max;
    logic [2:0]                       test_sel;
    logic [PULSE_W-1:0]               test_pulse;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic en1;
    logic en2;
    logic en3;
    logic en4;
  } lane_ctrl_t;

  typedef struct packed {
    logic en_mix;
    logic en_out;
  } mix_ctrl_t;

endpackage

FILE: rtl/qrpm_regs.sv
module qrpm_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qrpm_pkg::ADDR_W-1:0]    paddr,
  input  logic [qrpm_pkg::DATA_W-1:0]    pwdata,
  output logic [qrpm_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output qrpm_pkg::cfg_t                 cfg
);
  import qrpm_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:3];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gains      <= '0;
      cfg.motor_min  <= MOTOR_MIN_RST;
      cfg.motor_max  <= MOTOR_MAX_RST;
      cfg.test_sel   <= TSEL_NONE;
      cfg.test_pulse <= '0;
    end else if (wr) begin
      case (idx)
        REG_PITCH_GAINS: cfg.gains[AXIS_PITCH] <= pwdata[GAINS_W-1:0];
        REG_ROLL_GAINS:  cfg.gains[AXIS_ROLL]  <= pwdata[GAINS_W-1:0];
        REG_YAW_GAINS:   cfg.gains[AXIS_YAW]   <= pwdata[GAINS_W-1:0];
        REG_MOTOR_MIN:   cfg.motor_min         <= pwdata[PULSE_W-1:0];
        REG_MOTOR_MAX:   cfg.motor_max         <= pwdata[PULSE_W-1:0];
        REG_TEST_SEL:    cfg.test_sel          <= pwdata[2:0];
        REG_TEST_PULSE:  cfg.test_pulse        <= pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_PITCH_GAINS: prdata = DATA_W'(cfg.gains[AXIS_PITCH]);
      REG_ROLL_GAINS:  prdata = DATA_W'(cfg.gains[AXIS_ROLL]);
      REG_YAW_GAINS:   prdata = DATA_W'(cfg.gains[AXIS_YAW]);
      REG_MOTOR_MIN:   prdata = DATA_W'(cfg.motor_min);
      REG_MOTOR_MAX:   prdata = DATA_W'(cfg.motor_max);
      REG_TEST_SEL:    prdata = DATA_W'(cfg.test_sel);
      REG_TEST_PULSE:  prdata = DATA_W'(cfg.test_pulse);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/qrpm_axis_lane.sv
module qrpm_axis_lane (
  input  logic                                   clk,
  input  logic                                   rst,
  input  qrpm_pkg::lane_ctrl_t                   ctrl,
  input  logic signed [qrpm_pkg::RATE_W-1:0]     target,
  input  logic signed [qrpm_pkg::RATE_W-1:0]     rate,
  input  logic [qrpm_pkg::GAINS_W-1:0]           gains,
  output logic signed [qrpm_pkg::TERM_W-1:0]     term
);
  import qrpm_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((1 << TERM_SHIFT) - 1);

  logic signed [SUM_W-1:0]  error_sum;
  logic signed [ERR_W-1:0]  last_error;

  logic signed [ERR_W-1:0]  err_c;
  logic signed [DERR_W-1:0] derr_c;
  logic signed [SUM_W:0]    sum_c;
  logic signed [SUM_W-1:0]  sat_c;

  logic signed [ERR_W-1:0]  s1_err;
  logic signed [DERR_W-1:0] s1_derr;
  logic signed [SUM_W-1:0]  s1_sum;

  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;

  logic signed [PP_W-1:0]   pp;
  logic signed [PI_W-1:0]   pi;
  logic signed [PD_W-1:0]   pd;

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_adj;

  assign kp = gains[3*GAIN_W-1:2*GAIN_W];
  assign ki = gains[2*GAIN_W-1:GAIN_W];
  assign kd = gains[GAIN_W-1:0];

  // Error, derivative difference and saturating integral
  always_comb begin
    err_c  = ERR_W'(target) - ERR_W'(rate);
    derr_c = DERR_W'(err_c) - DERR_W'(last_error);
    sum_c  = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err_c);
    if (sum_c[SUM_W] != sum_c[SUM_W-1]) begin
      sat_c = sum_c[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_c = sum_c[SUM_W-1:0];
    end
  end

  // Update axis state once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (ctrl.accept) begin
      error_sum  <= sat_c;
      last_error <= err_c;
    end
  end

  // Stage 1: operands
  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      s1_err  <= err_c;
      s1_derr <= derr_c;
      s1_sum  <= sat_c;
    end
  end

  // Stage 2: gain products
  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      pp <= PP_W'(kp) * PP_W'(s1_err);
      pi <= PI_W'(ki) * PI_W'(s1_sum);
      pd <= PD_W'(kd) * PD_W'(s1_derr);
    end
  end

  // Stage 3: accumulate
  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      acc <= ACC_W'(pp) + ACC_W'(pi) + ACC_W'(pd);
    end
  end

  // Stage 4: shift to microseconds, rounding toward zero
  assign acc_adj = acc + (acc[ACC_W-1] ? TRUNC_BIAS : '0);

  always_ff @(posedge clk) begin
    if (ctrl.en4) begin
      term <= acc_adj[ACC_W-1:TERM_SHIFT];
    end
  end

endmodule

FILE: rtl/qrpm_mixer.sv
module qrpm_mixer (
  input  logic                                 clk,
  input  qrpm_pkg::mix_ctrl_t                  ctrl,
  input  qrpm_pkg::cfg_t                       cfg,
  input  logic signed [qrpm_pkg::THR_W-1:0]    throttle,
  input  logic signed [qrpm_pkg::TERM_W-1:0]   term_pitch,
  input  logic signed [qrpm_pkg::TERM_W-1:0]   term_roll,
  input  logic signed [qrpm_pkg::TERM_W-1:0]   term_yaw,
  output qrpm_pkg::motor_t                     motor
);
  import qrpm_pkg::*;

  localparam logic [PULSE_W-1:0] PERIOD = PULSE_W'(PULSE_PERIOD);

  logic signed [MIX_W-1:0] thr_x;
  logic signed [MIX_W-1:0] p_x;
  logic signed [MIX_W-1:0] r_x;
  logic signed [MIX_W-1:0] y_x;

  logic signed [3:0][MIX_W-1:0] mix;
  logic [3:0][PULSE_W-1:0]      cmp;

  logic signed [MIX_W-1:0] min_x;
  logic signed [MIX_W-1:0] max_x;

  assign thr_x = MIX_W'(throttle);
  assign p_x   = MIX_W'(term_pitch);
  assign r_x   = MIX_W'(term_roll);
  assign y_x   = MIX_W'(term_yaw);
  assign min_x = MIX_W'({1'b0, cfg.motor_min});
  assign max_x = MIX_W'({1'b0, cfg.motor_max});

  // X-frame mix
  always_ff @(posedge clk) begin
    if (ctrl.en_mix) begin
      mix[0] <= thr_x + r_x + p_x + y_x;
      mix[1] <= thr_x + r_x - p_x - y_x;
      mix[2] <= thr_x - r_x - p_x + y_x;
      mix[3] <= thr_x - r_x + p_x - y_x;
    end
  end

  // Clamp, apply test override and convert to timer compare
  always_comb begin
    logic [PULSE_W-1:0] pulse;
    for (int m = 0; m < 4; m++) begin
      if ($signed(mix[m]) < min_x) begin
        pulse = cfg.motor_min;
      end else if ($signed(mix[m]) > max_x) begin
        pulse = cfg.motor_max;
      end else begin
        pulse = mix[m][PULSE_W-1:0];
      end
      if (cfg.test_sel == 3'(m + 1)) begin
        pulse = cfg.test_pulse;
      end
      cmp[m] = PERIOD - pulse;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctrl.en_out) begin
      motor.compare_one   <= cmp[0];
      motor.compare_two   <= cmp[1];
      motor.compare_three <= cmp[2];
      motor.compare_four  <= cmp[3];
    end
  end

endmodule

FILE: rtl/quad_rate_pid_mixer.sv
// motor_valid rises once an accepted sample has passed the lane, mix and output stages.
// Throughput: one transaction per cycle while motor_stall is low; six pipeline stages,
// each advancing whenever the stage after it is empty or moving, so bubbles collapse
// under stall. The per-axis integrator and previous-error update in the accept cycle.
// Reset (rst, synchronous): integrators and previous errors to zero, gains to zero,
// motor_min 1000, motor_max 2000, no test motor, test pulse zero, pipeline empty.
module quad_rate_pid_mixer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  qrpm_pkg::sample_t              sample,
  output logic                           motor_valid,
  input  logic                           motor_stall,
  output qrpm_pkg::motor_t               motor,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qrpm_pkg::ADDR_W-1:0]    paddr,
  input  logic [qrpm_pkg::DATA_W-1:0]    pwdata,
  output logic [qrpm_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import qrpm_pkg::*;

  cfg_t       cfg;
  lane_ctrl_t lane_ctrl;
  mix_ctrl_t  mix_ctrl;

  // Stage valids: stages 1 to 4 in the lanes, stage 5 mix, then output
  logic [5:1] v;
  logic [6:1] rdy;
  logic       accept;

  logic signed [THR_W-1:0] thr_pipe [4:1];
  logic signed [TERM_W-1:0] term_p;
  logic signed [TERM_W-1:0] term_r;
  logic signed [TERM_W-1:0] term_y;

  qrpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Ready chain from the output back to the input
  always_comb begin
    rdy[6] = !motor_valid || !motor_stall;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign sample_stall = !rdy[1];
  assign accept       = sample_valid && rdy[1];

  assign lane_ctrl.accept = accept;
  assign lane_ctrl.en1    = rdy[1];
  assign lane_ctrl.en2    = rdy[2];
  assign lane_ctrl.en3    = rdy[3];
  assign lane_ctrl.en4    = rdy[4];
  assign mix_ctrl.en_mix  = rdy[5];
  assign mix_ctrl.en_out  = rdy[6];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v           <= '0;
      motor_valid <= 1'b0;
    end else begin
      if (rdy[1]) v[1] <= sample_valid;
      for (int k = 2; k <= 5; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
      if (rdy[6]) motor_valid <= v[5];
    end
  end

  // Carry throttle alongside the lanes
  always_ff @(posedge clk) begin
    if (rdy[1]) thr_pipe[1] <= sample.throttle;
    for (int k = 2; k <= 4; k++) begin
      if (rdy[k]) thr_pipe[k] <= thr_pipe[k-1];
    end
  end

  qrpm_axis_lane u_lane_pitch (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (lane_ctrl),
    .target (sample.target_pitch),
    .rate   (sample.rate_pitch),
    .gains  (cfg.gains[AXIS_PITCH]),
    .term   (term_p)
  );

  qrpm_axis_lane u_lane_roll (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (lane_ctrl),
    .target (sample.target_roll),
    .rate   (sample.rate_roll),
    .gains  (cfg.gains[AXIS_ROLL]),
    .term   (term_r)
  );

  qrpm_axis_lane u_lane_yaw (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (lane_ctrl),
    .target (sample.target_yaw),
    .rate   (sample.rate_yaw),
    .gains  (cfg.gains[AXIS_YAW]),
    .term   (term_y)
  );

  qrpm_mixer u_mixer (
    .clk        (clk),
    .ctrl       (mix_ctrl),
    .cfg        (cfg),
    .throttle   (thr_pipe[4]),
    .term_pitch (term_p),
    .term_roll  (term_r),
    .term_yaw   (term_y),
    .motor      (motor)
  );

endmodule

FILE: dv/testbench.sv
module testbench;
  import qrpm_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 180;
  localparam int WINDUP_ITEMS  = 200;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  // Write to an index past the last register must be ignored
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [2:0]           TSEL_UNUSED  = 3'd7;

  localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  sample_t             sample       = '0;
  logic                motor_valid;
  logic                motor_stall  = 1'b0;
  motor_t              motor;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  quad_rate_pid_mixer dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .motor_valid  (motor_valid),
    .motor_stall  (motor_stall),
    .motor        (motor),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Controller copy: register settings and per-axis loop state
  logic [GAINS_W-1:0] gains_m [NUM_AXES];
  logic [PULSE_W-1:0] min_pulse_m  = MOTOR_MIN_RST;
  logic [PULSE_W-1:0] max_pulse_m  = MOTOR_MAX_RST;
  logic [2:0]         test_sel_m   = TSEL_NONE;
  logic [PULSE_W-1:0] test_pulse_m = '0;
  longint             integ_m    [NUM_AXES];
  longint             prev_err_m [NUM_AXES];

  sample_t pending_samples [$];
  motor_t  want_motors [$];

  int items_queued    = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int settings_count  = 0;
  int tx_idle_max     = 12;
  int rx_idle_max     = 12;
  int tx_wait         = 0;
  int rx_wait         = 0;
  int rx_next;
  int hold_left       = 0;
  bit hold_done       = 1'b0;
  int cycle_count     = 0;
  motor_t want;

  initial begin
    for (int a = 0; a < NUM_AXES; a++) begin
      gains_m[a]    = '0;
      integ_m[a]    = 0;
      prev_err_m[a] = 0;
    end
  end

  // PID term for one axis in whole microseconds; updates integrator and last error
  function automatic longint axis_term(int ax, logic signed [15:0] tgt,
                                       logic signed [15:0] rt);
    longint err, sum, kp, ki, kd, acc;
    err = longint'(tgt) - longint'(rt);
    sum = integ_m[ax] + err;
    if (sum > SUM_HI) sum = SUM_HI;
    else if (sum < SUM_LO) sum = SUM_LO;
    kp  = longint'($signed(gains_m[ax][47:32]));
    ki  = longint'($signed(gains_m[ax][31:16]));
    kd  = longint'($signed(gains_m[ax][15:0]));
    acc = kp * err + ki * sum + kd * (err - prev_err_m[ax]);
    integ_m[ax]    = sum;
    prev_err_m[ax] = err;
    // Truncate toward zero, not floor
    if (acc < 0) return -((-acc) >>> TERM_SHIFT);
    return acc >>> TERM_SHIFT;
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_compare(longint v, logic [2:0] motor_no);
    longint pulse;
    if (v < longint'(min_pulse_m)) pulse = longint'(min_pulse_m);
    else if (v > longint'(max_pulse_m)) pulse = longint'(max_pulse_m);
    else pulse = v;
    if (test_sel_m == motor_no) pulse = longint'(test_pulse_m);
    return PULSE_W'(longint'(PULSE_PERIOD) - pulse);
  endfunction

  function automatic motor_t predict_motors(sample_t s);
    longint thr, p, r, y;
    motor_t m;
    thr = longint'(s.throttle);
    p   = axis_term(AXIS_PITCH, s.target_pitch, s.rate_pitch);
    r   = axis_term(AXIS_ROLL, s.target_roll, s.rate_roll);
    y   = axis_term(AXIS_YAW, s.target_yaw, s.rate_yaw);
    m.compare_one   = pulse_compare(thr + r + p + y, TSEL_ONE);
    m.compare_two   = pulse_compare(thr + r - p - y, TSEL_TWO);
    m.compare_three = pulse_compare(thr - r - p + y, TSEL_THREE);
    m.compare_four  = pulse_compare(thr - r + p - y, TSEL_FOUR);
    return m;
  endfunction

  function automatic sample_t make_sample(int thr, int tp, int tr, int ty,
                                          int rp, int rr, int ry);
    sample_t s;
    s.throttle     = 13'(thr);
    s.target_pitch = 16'(tp);
    s.target_roll  = 16'(tr);
    s.target_yaw   = 16'(ty);
    s.rate_pitch   = 16'(rp);
    s.rate_roll    = 16'(rr);
    s.rate_yaw     = 16'(ry);
    return s;
  endfunction

  function automatic logic [15:0] edge_value(int w);
    case ($urandom_range(0, 4))
      0:       return 16'(1 << (w - 1));
      1:       return 16'((1 << (w - 1)) - 1);
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly near-hover samples, then full-range noise and field extremes
  function automatic sample_t rand_sample();
    sample_t s;
    int tgt [3];
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      for (int a = 0; a < 3; a++) tgt[a] = int'($urandom_range(0, 4000)) - 2000;
      s = make_sample(int'($urandom_range(800, 2200)), tgt[0], tgt[1], tgt[2],
                      tgt[0] + int'($urandom_range(0, 512)) - 256,
                      tgt[1] + int'($urandom_range(0, 512)) - 256,
                      tgt[2] + int'($urandom_range(0, 512)) - 256);
    end else if (kind < 9) begin
      s.throttle     = 13'($urandom);
      s.target_pitch = 16'($urandom);
      s.target_roll  = 16'($urandom);
      s.target_yaw   = 16'($urandom);
      s.rate_pitch   = 16'($urandom);
      s.rate_roll    = 16'($urandom);
      s.rate_yaw     = 16'($urandom);
    end else begin
      s.throttle     = 13'(edge_value(13));
      s.target_pitch = edge_value(16);
      s.target_roll  = edge_value(16);
      s.target_yaw   = edge_value(16);
      s.rate_pitch   = edge_value(16);
      s.rate_roll    = edge_value(16);
      s.rate_yaw     = edge_value(16);
    end
    return s;
  endfunction

  function automatic logic [63:0] rand_gains(bit tame);
    logic [63:0] g;
    g = '0;
    for (int i = 0; i < 3; i++) begin
      if (tame) g[16*i +: 16] = 16'(int'($urandom_range(0, 1536)) - 768);
      else g[16*i +: 16] = 16'($urandom);
    end
    return g;
  endfunction

  function automatic int rand_idle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 12;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Register write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PITCH_GAINS: gains_m[AXIS_PITCH] = val[GAINS_W-1:0];
      REG_ROLL_GAINS:  gains_m[AXIS_ROLL]  = val[GAINS_W-1:0];
      REG_YAW_GAINS:   gains_m[AXIS_YAW]   = val[GAINS_W-1:0];
      REG_MOTOR_MIN:   min_pulse_m  = val[PULSE_W-1:0];
      REG_MOTOR_MAX:   max_pulse_m  = val[PULSE_W-1:0];
      REG_TEST_SEL:    test_sel_m   = val[2:0];
      REG_TEST_PULSE:  test_pulse_m = val[PULSE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_sample(sample_t s);
    pending_samples.push_back(s);
    items_queued++;
  endtask

  // Wait until every queued sample has produced its motor transaction
  task automatic drain();
    while (results_checked < items_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    int lo, hi;
    reg_write(REG_PITCH_GAINS, rand_gains($urandom_range(0, 3) != 0));
    reg_write(REG_ROLL_GAINS, rand_gains($urandom_range(0, 3) != 0));
    reg_write(REG_YAW_GAINS, rand_gains($urandom_range(0, 3) != 0));
    case ($urandom_range(0, 3))
      0: begin
        lo = 1000;
        hi = 2000;
      end
      1: begin
        lo = $urandom_range(0, 2100);
        hi = $urandom_range(lo, 2100);
      end
      2: begin
        hi = $urandom_range(0, 2000);
        lo = $urandom_range(hi + 1, 2100);
      end
      default: begin
        lo = $urandom_range(0, 4095);
        hi = $urandom_range(0, 4095);
      end
    endcase
    reg_write(REG_MOTOR_MIN, 64'(lo));
    reg_write(REG_MOTOR_MAX, 64'(hi));
    reg_write(REG_TEST_SEL, 64'($urandom_range(0, 7)));
    reg_write(REG_TEST_PULSE, 64'($urandom_range(0, 4095)));
    tx_idle_max = rand_idle();
    rx_idle_max = rand_idle();
    settings_count++;
  endtask

  // Sample driver: hold while stalled, predict on acceptance, then idle
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      tx_wait      <= 0;
    end else if (!(sample_valid && sample_stall)) begin
      if (sample_valid) want_motors.push_back(predict_motors(sample));
      if (tx_wait > 0) begin
        sample_valid <= 1'b0;
        tx_wait      <= tx_wait - 1;
      end else if (pending_samples.size() != 0) begin
        sample       <= pending_samples.pop_front();
        sample_valid <= 1'b1;
        tx_wait      <= $urandom_range(0, tx_idle_max);
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once, so the pipeline fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_checked >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Motor monitor: check against the oldest prediction, then draw a stall gap
  always @(posedge clk) begin
    if (rst) begin
      motor_stall <= 1'b0;
      rx_wait     <= 0;
    end else begin
      rx_next = rx_wait;
      if (motor_valid && !motor_stall) begin
        if (want_motors.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected motor transaction %h %h %h %h", motor.compare_one,
                     motor.compare_two, motor.compare_three, motor.compare_four);
        end else begin
          want = want_motors.pop_front();
          if (motor.compare_one !== want.compare_one ||
              motor.compare_two !== want.compare_two ||
              motor.compare_three !== want.compare_three ||
              motor.compare_four !== want.compare_four) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("motor mismatch at cycle %0d: got %h %h %h %h, want %h %h %h %h",
                       cycle_count, motor.compare_one, motor.compare_two,
                       motor.compare_three, motor.compare_four, want.compare_one,
                       want.compare_two, want.compare_three, want.compare_four);
          end
        end
        results_checked++;
        rx_next = $urandom_range(0, rx_idle_max);
      end else if (rx_wait > 0) begin
        rx_next = rx_wait - 1;
      end
      rx_wait     <= rx_next;
      motor_stall <= (rx_next > 0) || (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    sample_t s;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Known gains, default clamp: first sample, negative terms, field extremes
    reg_write(REG_PITCH_GAINS, 64'({16'h0100, 16'h0010, 16'h0080}));
    reg_write(REG_ROLL_GAINS, 64'({16'h0180, 16'h0008, 16'h0040}));
    reg_write(REG_YAW_GAINS, 64'({16'hFF00, 16'h0004, 16'hFFC0}));
    settings_count++;
    push_sample(make_sample(1500, 160, 0, 0, 0, 0, 0));
    push_sample(make_sample(1500, 160, 0, 0, 0, 0, 0));
    push_sample(make_sample(1500, -100, -37, 5, 37, 0, -3));
    push_sample(make_sample(1500, -1, -1, -1, 0, 0, 0));
    push_sample(make_sample(4095, 0, 0, 0, 0, 0, 0));
    push_sample(make_sample(-4096, 0, 0, 0, 0, 0, 0));
    push_sample(make_sample(1500, 32767, -32768, 32767, -32768, 32767, -32768));
    push_sample(make_sample(1500, -32768, 32767, -32768, 32767, -32768, 32767));
    push_sample(make_sample(0, 0, 0, 0, 0, 0, 0));
    drain();

    // Extreme gains with min above max
    reg_write(REG_PITCH_GAINS, 64'({16'h7FFF, 16'h7FFF, 16'h7FFF}));
    reg_write(REG_ROLL_GAINS, 64'({16'h8000, 16'h8000, 16'h8000}));
    reg_write(REG_YAW_GAINS, 64'({16'hFFFF, 16'hFFFF, 16'hFFFF}));
    reg_write(REG_MOTOR_MIN, 64'(1500));
    reg_write(REG_MOTOR_MAX, 64'(1200));
    settings_count++;
    push_sample(make_sample(1000, 0, 0, 0, 0, 0, 0));
    push_sample(make_sample(1300, 0, 0, 0, 0, 0, 0));
    push_sample(make_sample(1600, 0, 0, 0, 0, 0, 0));
    push_sample(make_sample(1500, 200, -200, 50, -200, 200, -50));
    drain();

    // Zero gains, wide clamp: pulses above period, test motor on each output
    reg_write(REG_PITCH_GAINS, 64'(0));
    reg_write(REG_ROLL_GAINS, 64'(0));
    reg_write(REG_YAW_GAINS, 64'(0));
    reg_write(REG_MOTOR_MIN, 64'(0));
    reg_write(REG_MOTOR_MAX, 64'(4095));
    reg_write(REG_TEST_PULSE, 64'(4095));
    reg_write(REG_TEST_SEL, 64'(TSEL_TWO));
    settings_count++;
    push_sample(make_sample(2500, 0, 0, 0, 0, 0, 0));
    push_sample(make_sample(-200, 0, 0, 0, 0, 0, 0));
    drain();
    reg_write(REG_TEST_PULSE, 64'(0));
    reg_write(REG_TEST_SEL, 64'(TSEL_FOUR));
    push_sample(make_sample(1800, 0, 0, 0, 0, 0, 0));
    drain();
    reg_write(REG_TEST_PULSE, 64'(2100));
    reg_write(REG_TEST_SEL, 64'(TSEL_THREE));
    push_sample(make_sample(1800, 0, 0, 0, 0, 0, 0));
    drain();
    reg_write(REG_TEST_SEL, 64'(TSEL_ONE));
    push_sample(make_sample(2200, 0, 0, 0, 0, 0, 0));
    drain();
    reg_write(REG_TEST_SEL, 64'(TSEL_UNUSED));
    reg_write(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
    push_sample(make_sample(1700, 0, 0, 0, 0, 0, 0));
    drain();

    // Random settings and samples, first half
    for (int ph = 0; ph < PHASE_COUNT / 2; ph++) begin
      random_config();
      repeat (PHASE_ITEMS) push_sample(rand_sample());
      drain();
    end

    // Drive pitch integrator steadily up and roll steadily down
    reg_write(REG_PITCH_GAINS, rand_gains(1'b1));
    reg_write(REG_ROLL_GAINS, rand_gains(1'b1));
    reg_write(REG_MOTOR_MIN, 64'(MOTOR_MIN_RST));
    reg_write(REG_MOTOR_MAX, 64'(MOTOR_MAX_RST));
    reg_write(REG_TEST_SEL, 64'(TSEL_NONE));
    settings_count++;
    tx_idle_max = 0;
    rx_idle_max = 0;
    repeat (WINDUP_ITEMS) begin
      s = rand_sample();
      s.target_pitch = 16'sh7FFF;
      s.rate_pitch   = 16'sh8000;
      s.target_roll  = 16'sh8000;
      s.rate_roll    = 16'sh7FFF;
      push_sample(s);
    end
    drain();

    // Random settings and samples, second half, starting from large integrators
    for (int ph = PHASE_COUNT / 2; ph < PHASE_COUNT; ph++) begin
      random_config();
      repeat (PHASE_ITEMS) push_sample(rand_sample());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run: %0d gyro sample transactions checked over %0d register settings",
             results_checked, settings_count);
    $display("run: %0d mismatches, integrators driven hard both ways, one long output hold",
             mismatches);
    if (mismatches == 0 && want_motors.size() == 0 && pending_samples.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/qrpm_pkg.sv
rtl/qrpm_regs.sv
rtl/qrpm_axis_lane.sv
rtl/qrpm_mixer.sv
rtl/quad_rate_pid_mixer.sv
dv/testbench.sv
